// ----- rtl/skf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// skf_pkg
// Shared widths, constants and register codes for the scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int DATA_W  = 32;              // Q16.16 sample, estimate, noise
  localparam int APB_W   = 32;              // APB data bus
  localparam int ADDR_W  = 3;               // two registers at 0x0 and 0x4
  localparam int GAIN_W  = 16;              // gain, unsigned Q0.16
  localparam int FRAC_W  = 16;              // fraction bits of Q16.16
  localparam int QUOT_W  = GAIN_W + 1;      // raw quotient, may reach 1.0
  localparam int DIV_STEPS = QUOT_W;        // one quotient bit per step
  localparam int CNT_W   = $clog2(DIV_STEPS);
  localparam int REM_W   = DATA_W + 2;      // partial remainder
  localparam int MUL_A_W = GAIN_W + 2;      // signed gain operand
  localparam int MUL_B_W = DATA_W + 2;      // signed diff / pred operand
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'd655;
  localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = 32'd65536;

  localparam logic [GAIN_W-1:0]  GAIN_MAX = 16'hFFFF;
  localparam logic [MUL_A_W-1:0] GAIN_ONE = 18'd65536;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_PROCESS_NOISE = 1'b0,
    REG_MEASURE_NOISE = 1'b1
  } skf_reg_t;

endpackage
`default_nettype wire

// ----- rtl/skf_sample_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// skf_sample_if
// Valid/ready channel carrying one signed Q16.16 measurement.
// ----------------------------------------------------------------------------
interface skf_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

// ----- rtl/skf_estimate_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// skf_estimate_if
// Valid/ready channel carrying one filtered signed Q16.16 estimate.
// ----------------------------------------------------------------------------
interface skf_estimate_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] estimate_out;

  modport source (output valid, output estimate_out, input ready);
  modport sink   (input valid, input estimate_out, output ready);
endinterface
`default_nettype wire

// ----- rtl/skf_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// skf_regs
// APB register file holding the process and measurement noise variances.
// ----------------------------------------------------------------------------
module skf_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [skf_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [skf_pkg::APB_W-1:0]   pwdata,
  output logic      [skf_pkg::APB_W-1:0]   prdata,
  output logic                             pready,
  output logic      [skf_pkg::DATA_W-1:0]  process_noise,
  output logic      [skf_pkg::DATA_W-1:0]  measure_noise
);
  import skf_pkg::*;

  skf_reg_t reg_sel;
  logic     wr_en;

  assign reg_sel = skf_reg_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise <= PROCESS_NOISE_RST;
      measure_noise <= MEASURE_NOISE_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_PROCESS_NOISE: process_noise <= pwdata[DATA_W-1:0];
        REG_MEASURE_NOISE: measure_noise <= pwdata[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PROCESS_NOISE: prdata = process_noise;
      REG_MEASURE_NOISE: prdata = measure_noise;
      default:           prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/skf_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// skf_div
// Radix-2 restoring divider: quotient = floor(dividend * 2^16 / divisor),
// valid while dividend <= divisor. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module skf_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [skf_pkg::DATA_W-1:0]   dividend,
  input  wire logic [skf_pkg::DATA_W:0]     divisor,
  output logic                              done,
  output logic      [skf_pkg::QUOT_W-1:0]   quotient
);
  import skf_pkg::*;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] dvs;
  logic [REM_W-1:0] rem_step;
  logic             fits;

  assign dvs      = {1'b0, divisor};
  assign fits     = rem >= dvs;
  assign rem_step = fits ? (rem - dvs) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // rem_step stays below the divisor, so the shift never loses a bit
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {2'b00, dividend};
      quotient <= '0;
    end else if (busy) begin
      rem      <= {rem_step[REM_W-2:0], 1'b0};
      quotient <= {quotient[QUOT_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/scalar_kalman_filter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// One-dimensional fixed-point Kalman filter with APB-programmable noise.
// ----------------------------------------------------------------------------
// Each accepted Q16.16 sample yields one filtered estimate. From its accept
// until the input is ready again a sample passes these steps in order: the
// predicted covariance is registered, the divider is launched, the radix-2 gain
// divider runs (one quotient bit per cycle) and signals done, two passes go
// through the shared 18x34 multiplier, and the estimate is written back once
// the output register is free. The input is not ready while a sample is in
// flight; a finished estimate waits in the output register, and the next
// sample is taken meanwhile. The user must write process_noise (0x0) and
// measure_noise (0x4) over APB only while the filter is idle; the block does not enforce it.
module scalar_kalman_filter (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [skf_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [skf_pkg::APB_W-1:0]   pwdata,
  output logic      [skf_pkg::APB_W-1:0]   prdata,
  output logic                             pready,
  skf_sample_if.sink                       samples,
  skf_estimate_if.source                   estimates
);
  import skf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_MUL_GAIN,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  state_t                    state;
  logic [DATA_W-1:0]         process_noise;
  logic [DATA_W-1:0]         measure_noise;
  logic signed [DATA_W-1:0]  sample_q;
  logic signed [DATA_W-1:0]  estimate;
  logic [DATA_W-1:0]         covariance;
  logic [DATA_W-1:0]         pred;
  logic                      denom_zero;
  logic [GAIN_W-1:0]         gain;
  logic signed [PROD_W-1:0]  prod;
  logic                      out_valid;
  logic signed [DATA_W-1:0]  out_data;

  logic [DATA_W:0]           pred_sum;
  logic [DATA_W-1:0]         pred_sat;
  logic [DATA_W:0]           denom;
  logic                      div_start;
  logic                      div_done;
  logic [QUOT_W-1:0]         quotient;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [MUL_B_W-1:0] diff;
  logic signed [PROD_W-FRAC_W:0] upd_sum;
  logic signed [DATA_W-1:0]  upd_sat;
  logic                      in_acc;
  logic                      finish_go;

  skf_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .process_noise (process_noise),
    .measure_noise (measure_noise)
  );

  assign denom     = {1'b0, pred} + {1'b0, measure_noise};
  assign div_start = (state == ST_DIV_START);

  skf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (pred),
    .divisor  (denom),
    .done     (div_done),
    .quotient (quotient)
  );

  assign samples.ready          = (state == ST_IDLE);
  assign in_acc                 = samples.valid && samples.ready;
  assign estimates.valid        = out_valid;
  assign estimates.estimate_out = out_data;

  // write back once the output register is free
  assign finish_go = (state == ST_FINISH) && (!out_valid || estimates.ready);

  // saturate the predicted covariance at all ones
  assign pred_sum = {1'b0, covariance} + {1'b0, process_noise};
  assign pred_sat = pred_sum[DATA_W] ? '1 : pred_sum[DATA_W-1:0];

  assign diff = MUL_B_W'(sample_q) - MUL_B_W'(estimate);

  // shared multiplier: gain * innovation, then (1 - gain) * predicted cov
  always_comb begin
    case (state)
      ST_MUL_GAIN: begin
        mul_a = signed'({2'b00, gain});
        mul_b = diff;
      end
      default: begin
        mul_a = signed'(GAIN_ONE - {2'b00, gain});
        mul_b = signed'({2'b00, pred});
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // arithmetic shift of the correction, then clamp to 32 bits
  assign upd_sum = (PROD_W-FRAC_W+1)'(estimate)
                 + (PROD_W-FRAC_W+1)'(signed'(prod[PROD_W-1:FRAC_W]));

  always_comb begin
    if (upd_sum[PROD_W-FRAC_W:DATA_W-1] == '0 ||
        upd_sum[PROD_W-FRAC_W:DATA_W-1] == '1) begin
      upd_sat = upd_sum[DATA_W-1:0];
    end else if (upd_sum[PROD_W-FRAC_W]) begin
      upd_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      upd_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      estimate   <= '0;
      covariance <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && estimates.ready && !finish_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            sample_q <= samples.sample;
            pred     <= pred_sat;
            state    <= ST_DIV_START;
          end
        end
        ST_DIV_START: begin
          denom_zero <= (denom == '0);
          state      <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            if (denom_zero) begin
              gain <= '0;
            end else if (quotient[QUOT_W-1]) begin
              gain <= GAIN_MAX;
            end else begin
              gain <= quotient[GAIN_W-1:0];
            end
            state <= ST_MUL_GAIN;
          end
        end
        ST_MUL_GAIN: begin
          prod  <= mul_p;
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          estimate <= upd_sat;
          prod     <= mul_p;
          state    <= ST_FINISH;
        end
        ST_FINISH: begin
          // hold until the output register is free
          if (finish_go) begin
            covariance <= prod[DATA_W+FRAC_W-1:FRAC_W];
            out_data   <= estimate;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/skf_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// skf_checker
// Port-level checks on the filter's sample and estimate channels.
// ----------------------------------------------------------------------------
module skf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] estimate_out
);

  // a stalled estimate holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(estimate_out))
    else $error("estimate transaction changed while stalled");

  // an accepted sample keeps the input busy for the start of the filter step
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input ready again too soon after a sample transaction");

  // the input goes busy only by accepting a sample
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid))
    else $error("input went busy without a sample transaction");

  // a new estimate appears only as the filter returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("estimate raised while a sample is still in flight");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (samples.valid),
  .in_ready     (samples.ready),
  .out_valid    (estimates.valid),
  .out_ready    (estimates.ready),
  .estimate_out (estimates.estimate_out)
);
`default_nettype wire
